### rtl/plbu_pkg.sv
// shared types and constants for the price level book update block
// no dependencies; used by every module of the block
`default_nettype none

package plbu_pkg;

    localparam int LEVELS_DEF     = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int QTY_BITS_DEF   = 32;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_EVICTED  = 3'd4,
        ST_DROPPED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    // broadcast control into every cell of one side
    typedef struct packed {
        logic     cmp_en;
        logic     is_ask;
        cell_op_t op;
    } side_ctl_t;

    // summary flags of one side back to the controller
    typedef struct packed {
        logic any_match;
        logic full;
        logic all_before;
    } side_stat_t;

endpackage

`default_nettype wire

### rtl/price_level_book_update.sv
// top level of the price level book update block: control and two book sides
// depends on plbu_pkg and plbu_side
`default_nettype none

// One update is taken when start is high and busy is low. Its result is on the
// ports as a one-cycle done beat in state S_DONE, which follows S_CMP and
// S_APPLY, and busy is low during that cycle, so a new update can be taken in
// the done cycle but not in S_CMP or S_APPLY. In S_CMP all cells of a side
// compare against the new price in parallel; in S_APPLY the chain shifts or
// rewrites in place. The receiver cannot stall the block; status and the best
// bid and ask (after the update) must be taken while done is high. Each side
// holds up to LEVELS levels in a row of cells; a full side evicts its worst
// level or drops a new level that would be worst.
module price_level_book_update #(
    parameter int LEVELS     = plbu_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plbu_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = plbu_pkg::QTY_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire                     side,
    input  wire  [PRICE_BITS-1:0]   price,
    input  wire  [QTY_BITS-1:0]     qty,
    output logic                    done,
    output logic [2:0]              status,
    output logic                    bid_valid,
    output logic [PRICE_BITS-1:0]   bid_top_price,
    output logic [QTY_BITS-1:0]     bid_top_qty,
    output logic                    ask_valid,
    output logic [PRICE_BITS-1:0]   ask_top_price,
    output logic [QTY_BITS-1:0]     ask_top_qty
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    plbu_pkg::status_t     status_reg, status_next;

    plbu_pkg::side_ctl_t   bid_ctl, ask_ctl;
    plbu_pkg::side_stat_t  bid_stat, ask_stat, sel_stat;
    plbu_pkg::cell_op_t    op;
    logic                  accept;
    logic                  qty_zero;

    assign accept   = start && !busy;
    assign busy     = (state_reg == S_CMP) || (state_reg == S_APPLY);
    assign qty_zero = (qty_reg == '0);
    assign sel_stat = side_reg ? ask_stat : bid_stat;

    always_comb
    begin
        op          = plbu_pkg::OP_NONE;
        status_next = status_reg;
        if (sel_stat.any_match)
        begin
            op          = qty_zero ? plbu_pkg::OP_REMOVE : plbu_pkg::OP_UPDATE;
            status_next = qty_zero ? plbu_pkg::ST_REMOVED : plbu_pkg::ST_UPDATED;
        end
        else if (qty_zero)
        begin
            status_next = plbu_pkg::ST_IGNORED;
        end
        else if (sel_stat.full && sel_stat.all_before)
        begin
            status_next = plbu_pkg::ST_DROPPED;
        end
        else
        begin
            op          = plbu_pkg::OP_INSERT;
            status_next = sel_stat.full ? plbu_pkg::ST_EVICTED : plbu_pkg::ST_INSERTED;
        end
        if (state_reg != S_APPLY)
        begin
            op          = plbu_pkg::OP_NONE;
            status_next = status_reg;
        end

        bid_ctl.cmp_en = (state_reg == S_CMP) && !side_reg;
        bid_ctl.is_ask = 1'b0;
        bid_ctl.op     = side_reg ? plbu_pkg::OP_NONE : op;
        ask_ctl.cmp_en = (state_reg == S_CMP) && side_reg;
        ask_ctl.is_ask = 1'b1;
        ask_ctl.op     = side_reg ? op : plbu_pkg::OP_NONE;
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = S_DONE;
            S_DONE:  state_next = accept ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= plbu_pkg::ST_UPDATED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= qty;
        end
    end

    plbu_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bid_ctl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .stat       (bid_stat),
        .top_valid  (bid_valid),
        .top_price  (bid_top_price),
        .top_qty    (bid_top_qty)
    );

    plbu_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ask_ctl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .stat       (ask_stat),
        .top_valid  (ask_valid),
        .top_price  (ask_top_price),
        .top_qty    (ask_top_qty)
    );

    assign done   = (state_reg == S_DONE);
    assign status = status_reg;

    // every accepted beat gets its result beat on done after S_CMP and S_APPLY
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result beat missing after accepted update");

    // an inserted level leaves its side non-empty
    a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg == plbu_pkg::ST_INSERTED || status_reg == plbu_pkg::ST_EVICTED)
        |-> (side_reg ? ask_valid : bid_valid))
        else $error("insert left side empty");

    // eviction leaves the side still full
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg == plbu_pkg::ST_EVICTED |-> sel_stat.full)
        else $error("eviction on a side that is not full");

endmodule

`default_nettype wire

### rtl/plbu_cell.sv
// one price level cell of a sorted level chain
// depends on plbu_pkg
`default_nettype none

module plbu_cell #(
    parameter int PRICE_BITS = plbu_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = plbu_pkg::QTY_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  plbu_pkg::side_ctl_t     ctl,
    input  wire  [PRICE_BITS-1:0]   new_price,
    input  wire  [QTY_BITS-1:0]     new_qty,
    input  wire  [PRICE_BITS-1:0]   prv_price,
    input  wire  [QTY_BITS-1:0]     prv_qty,
    input  wire                     prv_valid,
    input  wire                     prv_before,
    input  wire  [PRICE_BITS-1:0]   nxt_price,
    input  wire  [QTY_BITS-1:0]     nxt_qty,
    input  wire                     nxt_valid,
    output logic [PRICE_BITS-1:0]   price,
    output logic [QTY_BITS-1:0]     qty,
    output logic                    valid,
    output logic                    ahead,
    output logic                    match
);

    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    logic                  valid_reg, valid_next;
    logic                  before_reg, before_next;
    logic                  match_reg, match_next;
    logic                  beats;

    always_comb
    begin
        beats = ctl.is_ask ? (price_reg < new_price) : (price_reg > new_price);
        before_next = before_reg;
        match_next  = match_reg;
        if (ctl.cmp_en)
        begin
            before_next = valid_reg && beats;
            match_next  = valid_reg && (price_reg == new_price);
        end

        price_next = price_reg;
        qty_next   = qty_reg;
        valid_next = valid_reg;
        case (ctl.op)
            plbu_pkg::OP_UPDATE:
            begin
                if (match_reg)
                begin
                    qty_next = new_qty;
                end
            end
            plbu_pkg::OP_REMOVE:
            begin
                if (!before_reg)
                begin
                    price_next = nxt_price;
                    qty_next   = nxt_qty;
                    valid_next = nxt_valid;
                end
            end
            plbu_pkg::OP_INSERT:
            begin
                if (!before_reg)
                begin
                    if (prv_before)
                    begin
                        price_next = new_price;
                        qty_next   = new_qty;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        price_next = prv_price;
                        qty_next   = prv_qty;
                        valid_next = prv_valid;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            before_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            before_reg <= before_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign price = price_reg;
    assign qty   = qty_reg;
    assign valid = valid_reg;
    assign ahead = before_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

### rtl/plbu_side.sv
// one book side: a chain of level cells kept best-first
// depends on plbu_pkg and plbu_cell
`default_nettype none

module plbu_side #(
    parameter int LEVELS     = plbu_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plbu_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = plbu_pkg::QTY_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  plbu_pkg::side_ctl_t     ctl,
    input  wire  [PRICE_BITS-1:0]   new_price,
    input  wire  [QTY_BITS-1:0]     new_qty,
    output plbu_pkg::side_stat_t    stat,
    output logic                    top_valid,
    output logic [PRICE_BITS-1:0]   top_price,
    output logic [QTY_BITS-1:0]     top_qty
);

    logic [PRICE_BITS-1:0] cell_price [LEVELS];
    logic [QTY_BITS-1:0]   cell_qty   [LEVELS];
    logic [LEVELS-1:0]     cell_valid;
    logic [LEVELS-1:0]     cell_before;
    logic [LEVELS-1:0]     cell_match;

    genvar gi;
    generate
        for (gi = 0; gi < LEVELS; gi++)
        begin : g_cell
            logic [PRICE_BITS-1:0] p_price, n_price;
            logic [QTY_BITS-1:0]   p_qty, n_qty;
            logic                  p_valid, p_before, n_valid;

            if (gi == 0)
            begin : g_head
                assign p_price  = '0;
                assign p_qty    = '0;
                assign p_valid  = 1'b0;
                assign p_before = 1'b1;
            end
            else
            begin : g_body
                assign p_price  = cell_price[gi-1];
                assign p_qty    = cell_qty[gi-1];
                assign p_valid  = cell_valid[gi-1];
                assign p_before = cell_before[gi-1];
            end

            if (gi == LEVELS - 1)
            begin : g_tail
                assign n_price = '0;
                assign n_qty   = '0;
                assign n_valid = 1'b0;
            end
            else
            begin : g_link
                assign n_price = cell_price[gi+1];
                assign n_qty   = cell_qty[gi+1];
                assign n_valid = cell_valid[gi+1];
            end

            plbu_cell #(
                .PRICE_BITS (PRICE_BITS),
                .QTY_BITS   (QTY_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_price  (new_price),
                .new_qty    (new_qty),
                .prv_price  (p_price),
                .prv_qty    (p_qty),
                .prv_valid  (p_valid),
                .prv_before (p_before),
                .nxt_price  (n_price),
                .nxt_qty    (n_qty),
                .nxt_valid  (n_valid),
                .price      (cell_price[gi]),
                .qty        (cell_qty[gi]),
                .valid      (cell_valid[gi]),
                .ahead      (cell_before[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        stat.any_match  = |cell_match;
        stat.full       = cell_valid[LEVELS-1];
        stat.all_before = cell_before[LEVELS-1];
    end

    assign top_valid = cell_valid[0];
    assign top_price = cell_valid[0] ? cell_price[0] : '0;
    assign top_qty   = cell_valid[0] ? cell_qty[0] : '0;

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for price_level_book_update: directed and random book updates, predicted
// by a sorted two-sided level table and checked beat by beat on done; needs plbu_pkg and the rtl
`timescale 1ns / 1ps

localparam int BOOK_DEPTH = plbu_pkg::LEVELS_DEF;
localparam int PX_W       = plbu_pkg::PRICE_BITS_DEF;
localparam int QT_W       = plbu_pkg::QTY_BITS_DEF;

typedef struct packed {
    plbu_pkg::status_t status;
    logic              bid_valid;
    logic [PX_W-1:0]   bid_price;
    logic [QT_W-1:0]   bid_qty;
    logic              ask_valid;
    logic [PX_W-1:0]   ask_price;
    logic [QT_W-1:0]   ask_qty;
} book_view_t;

class book_scoreboard;
    logic [PX_W-1:0] lvl_price [2][BOOK_DEPTH];
    logic [QT_W-1:0] lvl_qty   [2][BOOK_DEPTH];
    int              lvl_cnt   [2];
    book_view_t      pending_tops[$];
    int              errors;
    int              beat_idx;

    function new();
        lvl_cnt[0] = 0;
        lvl_cnt[1] = 0;
        errors = 0;
        beat_idx = 0;
    endfunction

    task flag(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // one side of the book; index 0 is the best level
    function plbu_pkg::status_t apply_level(bit is_ask, logic [PX_W-1:0] px,
                                            logic [QT_W-1:0] qt);
        int n;
        int pos;
        int last;
        int i;
        plbu_pkg::status_t st;
        n = lvl_cnt[is_ask];
        pos = n;
        for (i = 0; i < n; i++) begin
            if (is_ask ? (lvl_price[is_ask][i] >= px) : (lvl_price[is_ask][i] <= px)) begin
                pos = i;
                break;
            end
        end
        if (pos < n && lvl_price[is_ask][pos] == px) begin
            if (qt == '0) begin
                for (i = pos; i + 1 < n; i++) begin
                    lvl_price[is_ask][i] = lvl_price[is_ask][i+1];
                    lvl_qty[is_ask][i]   = lvl_qty[is_ask][i+1];
                end
                lvl_cnt[is_ask] = n - 1;
                return plbu_pkg::ST_REMOVED;
            end
            lvl_qty[is_ask][pos] = qt;
            return plbu_pkg::ST_UPDATED;
        end
        if (qt == '0)
            return plbu_pkg::ST_IGNORED;
        st = plbu_pkg::ST_INSERTED;
        last = n;
        if (n >= BOOK_DEPTH) begin
            if (pos >= n)
                return plbu_pkg::ST_DROPPED;
            st = plbu_pkg::ST_EVICTED;
            last = n - 1;
        end
        for (i = last; i > pos; i--) begin
            lvl_price[is_ask][i] = lvl_price[is_ask][i-1];
            lvl_qty[is_ask][i]   = lvl_qty[is_ask][i-1];
        end
        lvl_price[is_ask][pos] = px;
        lvl_qty[is_ask][pos]   = qt;
        lvl_cnt[is_ask] = last + 1;
        return st;
    endfunction

    function void note_update(bit is_ask, logic [PX_W-1:0] px, logic [QT_W-1:0] qt);
        book_view_t v;
        v = '0;
        v.status = apply_level(is_ask, px, qt);
        if (lvl_cnt[0] > 0) begin
            v.bid_valid = 1'b1;
            v.bid_price = lvl_price[0][0];
            v.bid_qty   = lvl_qty[0][0];
        end
        if (lvl_cnt[1] > 0) begin
            v.ask_valid = 1'b1;
            v.ask_price = lvl_price[1][0];
            v.ask_qty   = lvl_qty[1][0];
        end
        pending_tops = {pending_tops, v};
    endfunction

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag($sformatf("beat %0d %s got %0h want %0h", beat_idx, name, got, want));
    endtask

    task check_result(book_view_t got);
        book_view_t want;
        if (pending_tops.size() == 0) begin
            flag($sformatf("beat %0d arrived with no update outstanding", beat_idx));
        end
        else begin
            want = pending_tops.pop_front();
            compare_field("status", 64'(got.status), 64'(want.status));
            compare_field("bid_valid", 64'(got.bid_valid), 64'(want.bid_valid));
            compare_field("bid_top_price", 64'(got.bid_price), 64'(want.bid_price));
            compare_field("bid_top_qty", 64'(got.bid_qty), 64'(want.bid_qty));
            compare_field("ask_valid", 64'(got.ask_valid), 64'(want.ask_valid));
            compare_field("ask_top_price", 64'(got.ask_price), 64'(want.ask_price));
            compare_field("ask_top_qty", 64'(got.ask_qty), 64'(want.ask_qty));
        end
        beat_idx++;
    endtask
endclass

module tb_top;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            side = 1'b0;
    logic [PX_W-1:0] price = '0;
    logic [QT_W-1:0] qty = '0;
    logic            busy;
    logic            done;
    logic [2:0]      status;
    logic            bid_valid;
    logic [PX_W-1:0] bid_top_price;
    logic [QT_W-1:0] bid_top_qty;
    logic            ask_valid;
    logic [PX_W-1:0] ask_top_price;
    logic [QT_W-1:0] ask_top_qty;

    book_scoreboard sb = new();

    price_level_book_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .side          (side),
        .price         (price),
        .qty           (qty),
        .done          (done),
        .status        (status),
        .bid_valid     (bid_valid),
        .bid_top_price (bid_top_price),
        .bid_top_qty   (bid_top_qty),
        .ask_valid     (ask_valid),
        .ask_top_price (ask_top_price),
        .ask_top_qty   (ask_top_qty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{plbu_pkg::status_t'(status), bid_valid, bid_top_price,
                              bid_top_qty, ask_valid, ask_top_price, ask_top_qty});
    end

    // called just after a rising edge; returns at the edge that takes the beat
    task send_update(bit s, logic [PX_W-1:0] p, logic [QT_W-1:0] q);
        start <= 1'b1;
        side  <= s;
        price <= p;
        qty   <= q;
        do
            @(posedge clk);
        while (busy);
        sb.note_update(s, p, q);
    endtask

    task idle(int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function int next_gap(bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [QT_W-1:0] pick_qty();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r < 5)
            return QT_W'($urandom_range(1, 1000));
        return QT_W'($urandom);
    endfunction

    task run_directed();
        bit              ds [20];
        logic [PX_W-1:0] dp [20];
        logic [QT_W-1:0] dq [20];
        int i;
        // empty book, insert, update, new best, worst, removes, absent-price zero
        ds = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1,
               1, 1, 1, 1, 0, 0, 1, 0, 1, 1};
        dp = '{32'd50, 32'd1000, 32'd1000, 32'd2000, 32'd0, 32'd0, 32'd2000, 32'd5000,
               32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd500, 32'hFFFFFFFF, 32'd1000,
               32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'h55555555};
        dq = '{32'd0, 32'd10, 32'd20, 32'hFFFFFFFF, 32'd1, 32'd0, 32'd0, 32'd0,
               32'd7, 32'hFFFFFFFF, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0,
               32'hAAAAAAAA, 32'h55555555, 32'h12345678, 32'hFFFFFFFF, 32'd0};
        for (i = 0; i < 20; i++)
        begin
            send_update(ds[i], dp[i], dq[i]);
            idle(next_gap(i < 10));
        end
    endtask

    initial
    begin : stimulus
        int              phase;
        int              k;
        int              kind;
        int              span;
        int              zero_pct;
        int              hit_pct;
        int              side_mode;
        int              guard;
        bit              no_idle;
        bit              s;
        logic [PX_W-1:0] base;
        logic [PX_W-1:0] top_base;
        logic [PX_W-1:0] p;
        logic [QT_W-1:0] q;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (phase = 0; phase < 16; phase++)
        begin
            // fill drives one side past full, churn mixes, drain mostly sends removes
            kind = (phase < 2) ? 0 : $urandom_range(0, 2);
            case (kind)
                0:
                begin
                    span = 300; zero_pct = 3; hit_pct = 15;
                    side_mode = $urandom_range(0, 1);
                end
                1:
                begin
                    span = 80; zero_pct = 35; hit_pct = 50; side_mode = 2;
                end
                default:
                begin
                    span = 80; zero_pct = 70; hit_pct = 80; side_mode = 2;
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            top_base = '1 - PX_W'(span);
            case ($urandom_range(0, 7))
                0: base = '0;
                1: base = top_base;
                default: base = PX_W'($urandom);
            endcase
            if (base > top_base)
                base = top_base;
            for (k = 0; k < 100; k++)
            begin
                s = (side_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(side_mode);
                if ($urandom_range(0, 99) < hit_pct && sb.lvl_cnt[s] > 0)
                    p = sb.lvl_price[s][$urandom_range(0, sb.lvl_cnt[s] - 1)];
                else
                    p = base + PX_W'($urandom_range(0, span));
                q = ($urandom_range(0, 99) < zero_pct) ? '0 : pick_qty();
                send_update(s, p, q);
                idle(next_gap(no_idle));
            end
        end
        start <= 1'b0;
        guard = 0;
        while (sb.pending_tops.size() != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_tops.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending_tops.size()));
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
